// File: rtl/core/lzwd_pkg.sv
package lzwd_pkg;

    // Sequencer states of the decoder.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_EMIT
    } t_state;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_CHUNK_LENGTH     = 2'd0,
        CFG_OBFUSCATE_ENABLE = 2'd1,
        CFG_KEY_SEED         = 2'd2
    } t_cfg_index;

    localparam int CFG_DATA_W  = 16;
    localparam int CFG_INDEX_W = 2;
    localparam int BYTE_W      = 8;
    localparam int BUF_W       = 24;
    localparam int CNT_W       = 5;
    localparam int COUNT_W     = 16;
    localparam int ACC_W       = 16;

    // Ring advance at the start of a chunk without context initialisation.
    localparam int RING_ADVANCE = 5;
    // Bits consumed by a literal token and by a match token.
    localparam int LIT_BITS     = 9;
    localparam int MATCH_BITS   = 11;
    // Shortest match length.
    localparam int MIN_MATCH    = 2;

endpackage

// File: rtl/core/lzwd_in_if.sv
interface lzwd_in_if
    import lzwd_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] packed_byte;
    logic              chunk_start;
    logic              init_context;
    logic              load_key;

    modport source (output valid, output packed_byte, output chunk_start,
                    output init_context, output load_key, input ready);
    modport sink   (input valid, input packed_byte, input chunk_start,
                    input init_context, input load_key, output ready);
endinterface

// File: rtl/core/lzwd_out_if.sv
interface lzwd_out_if
    import lzwd_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_byte;
    logic              last_of_run;
    logic              chunk_done;

    modport source (output valid, output out_byte, output last_of_run,
                    output chunk_done, input ready);
    modport sink   (input valid, input out_byte, input last_of_run,
                    input chunk_done, output ready);
endinterface

// File: rtl/core/lzwd_ram.sv
module lzwd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/core/lz_window256_bit_decoder.sv
// Bit-stream LZ decoder with a 256-byte ring window. Packed bytes arrive on the
// input channel, are optionally de-obfuscated with a 16-bit key accumulator and
// are read MSB first as literal tokens (flag 1, eight bits) and match tokens
// (flag 0, two-bit length 2..5, eight-bit back distance, overlap allowed). A
// request is accepted only while the sequencer is idle. A byte that completes
// no token, or arrives after the chunk is complete, leaves the sequencer idle; a
// literal passes through the emit state; each copied byte of a match needs a read
// state and then an emit state that writes the single window RAM, whose read data
// is registered. A waiting output request can delay the write.
// The window is cleared at once by reset or init_context through one valid bit
// per entry, so no clearing pass is needed.
module lz_window256_bit_decoder
    import lzwd_pkg::*;
#(
    parameter int WINDOW_DEPTH = 256
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    lzwd_in_if.sink                i_in,
    lzwd_out_if.source             o_out
);

    localparam int AW = $clog2(WINDOW_DEPTH);

    // Configuration registers.
    logic [COUNT_W-1:0] r_chunk_length;
    logic               r_obf_enable;
    logic [ACC_W-1:0]   r_key_seed;

    // Decoder state.
    t_state             r_state, n_state;
    logic [AW-1:0]      r_pos, n_pos;
    logic [BUF_W-1:0]   r_buf, n_buf;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [COUNT_W-1:0] r_emitted, n_emitted;
    logic [ACC_W-1:0]   r_acc, n_acc;
    logic [AW-1:0]      r_src, n_src;
    logic [2:0]         r_remaining, n_remaining;
    logic               r_is_lit, n_is_lit;
    logic [BYTE_W-1:0]  r_lit_byte, n_lit_byte;
    logic               r_valid [WINDOW_DEPTH];
    logic               r_rd_valid;

    // Output register.
    logic               r_out_valid, n_out_valid;
    logic [BYTE_W-1:0]  r_out_byte, n_out_byte;
    logic               r_out_last, n_out_last;
    logic               r_out_done, n_out_done;

    // Accept-cycle datapath.
    logic               w_accept;
    logic [AW-1:0]      w_pos0;
    logic [COUNT_W-1:0] w_emit0;
    logic [BUF_W-1:0]   w_buf0, w_buf1;
    logic [CNT_W-1:0]   w_cnt0, w_cnt1, w_cnt_lit, w_cnt_match;
    logic [ACC_W-1:0]   w_acc0, w_acc1;
    logic [BYTE_W-1:0]  w_plain;
    logic [BUF_W-1:0]   w_top, w_sh_lit, w_sh_match;
    logic               w_chunk_full;
    logic [AW-1:0]      w_match_src;
    logic               w_clear_valid;

    // Emit-cycle datapath.
    logic               w_out_free;
    logic [BYTE_W-1:0]  w_rdata, w_emit_byte;
    logic [COUNT_W:0]   w_emit_inc;
    logic               w_emit_done, w_emit_last;
    logic               w_ram_we, w_ram_re;

    assign i_in.ready = (r_state == ST_IDLE);
    assign w_accept   = i_in.valid && (r_state == ST_IDLE);

    // Context, chunk and key handling in their fixed order.
    assign w_pos0  = i_in.init_context ? '0
                   : (i_in.chunk_start ? r_pos + AW'(RING_ADVANCE) : r_pos);
    assign w_emit0 = i_in.chunk_start ? '0 : r_emitted;
    assign w_buf0  = i_in.chunk_start ? '0 : r_buf;
    assign w_cnt0  = i_in.chunk_start ? '0 : r_cnt;
    assign w_acc0  = i_in.load_key ? r_key_seed : r_acc;

    // De-obfuscation: XOR with the accumulator, which then takes in the raw byte.
    assign w_plain = r_obf_enable ? (i_in.packed_byte ^ w_acc0[BYTE_W-1:0])
                                  : i_in.packed_byte;
    assign w_acc1  = r_obf_enable
                   ? (w_acc0 >> 1) + ACC_W'(i_in.packed_byte) : w_acc0;

    assign w_chunk_full = (w_emit0 >= r_chunk_length);

    // Bit buffer with the new byte appended; tokens are read relative to the count.
    assign w_buf1      = {w_buf0[BUF_W-BYTE_W-1:0], w_plain};
    assign w_cnt1      = w_cnt0 + CNT_W'(BYTE_W);
    assign w_top       = w_buf1 >> (w_cnt1 - CNT_W'(1));
    assign w_sh_lit    = w_buf1 >> (w_cnt1 - CNT_W'(LIT_BITS));
    assign w_sh_match  = w_buf1 >> (w_cnt1 - CNT_W'(MATCH_BITS));
    assign w_cnt_lit   = w_cnt1 - CNT_W'(LIT_BITS);
    assign w_cnt_match = w_cnt1 - CNT_W'(MATCH_BITS);
    assign w_match_src = w_pos0 - AW'(w_sh_match[BYTE_W-1:0]) - AW'(1);

    assign w_clear_valid = w_accept && i_in.init_context;

    // Window byte for the current emit.
    assign w_out_free  = !r_out_valid || o_out.ready;
    assign w_emit_byte = r_is_lit ? r_lit_byte : (r_rd_valid ? w_rdata : '0);
    assign w_emit_inc  = {1'b0, r_emitted} + (COUNT_W+1)'(1);
    assign w_emit_done = (w_emit_inc >= {1'b0, r_chunk_length});
    assign w_emit_last = (r_remaining == 3'd1) || w_emit_done;
    assign w_ram_we    = (r_state == ST_EMIT) && w_out_free;
    assign w_ram_re    = (r_state == ST_READ);

    lzwd_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (WINDOW_DEPTH)
    ) u_window (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (r_pos),
        .i_wdata (w_emit_byte),
        .i_re    (w_ram_re),
        .i_raddr (r_src),
        .o_rdata (w_rdata)
    );

    // Sequencer: next state and datapath updates.
    always_comb begin
        n_state     = r_state;
        n_pos       = r_pos;
        n_buf       = r_buf;
        n_cnt       = r_cnt;
        n_emitted   = r_emitted;
        n_acc       = r_acc;
        n_src       = r_src;
        n_remaining = r_remaining;
        n_is_lit    = r_is_lit;
        n_lit_byte  = r_lit_byte;
        n_out_valid = r_out_valid && !o_out.ready;
        n_out_byte  = r_out_byte;
        n_out_last  = r_out_last;
        n_out_done  = r_out_done;

        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_pos     = w_pos0;
                    n_emitted = w_emit0;
                    n_acc     = w_acc1;
                    n_buf     = w_buf0;
                    n_cnt     = w_cnt0;
                    if (!w_chunk_full) begin
                        n_buf = w_buf1;
                        n_cnt = w_cnt1;
                        if (w_top[0]) begin
                            // Literal token.
                            if (w_cnt1 >= CNT_W'(LIT_BITS)) begin
                                n_cnt       = w_cnt_lit;
                                n_buf       = w_buf1 & ~({BUF_W{1'b1}} << w_cnt_lit);
                                n_is_lit    = 1'b1;
                                n_lit_byte  = w_sh_lit[BYTE_W-1:0];
                                n_remaining = 3'd1;
                                n_state     = ST_EMIT;
                            end
                        end else if (w_cnt1 >= CNT_W'(MATCH_BITS)) begin
                            // Match token.
                            n_cnt       = w_cnt_match;
                            n_buf       = w_buf1 & ~({BUF_W{1'b1}} << w_cnt_match);
                            n_is_lit    = 1'b0;
                            n_src       = w_match_src;
                            n_remaining = {1'b0, w_sh_match[BYTE_W+1:BYTE_W]}
                                        + 3'(MIN_MATCH);
                            n_state     = ST_READ;
                        end
                    end
                end
            end
            ST_READ: begin
                n_src   = r_src + AW'(1);
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_byte  = w_emit_byte;
                    n_out_last  = w_emit_last;
                    n_out_done  = w_emit_done;
                    n_pos       = r_pos + AW'(1);
                    n_emitted   = w_emit_inc[COUNT_W-1:0];
                    n_remaining = r_remaining - 3'd1;
                    n_state     = w_emit_last ? ST_IDLE : ST_READ;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Control and datapath registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_buf       <= '0;
            r_cnt       <= '0;
            r_emitted   <= '0;
            r_acc       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_pos       <= n_pos;
            r_buf       <= n_buf;
            r_cnt       <= n_cnt;
            r_emitted   <= n_emitted;
            r_acc       <= n_acc;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers of the copy and of the output.
    always_ff @(posedge i_clk) begin
        r_src       <= n_src;
        r_remaining <= n_remaining;
        r_is_lit    <= n_is_lit;
        r_lit_byte  <= n_lit_byte;
        r_out_byte  <= n_out_byte;
        r_out_last  <= n_out_last;
        r_out_done  <= n_out_done;
        if (w_ram_re) begin
            r_rd_valid <= r_valid[r_src];
        end
    end

    // Window valid bits: an entry never written since a clear reads as zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || w_clear_valid) begin
            for (int i = 0; i < WINDOW_DEPTH; i++) begin
                r_valid[i] <= 1'b0;
            end
        end else if (w_ram_we) begin
            r_valid[r_pos] <= 1'b1;
        end
    end

    // Configuration writes; an unknown index is ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chunk_length <= '0;
            r_obf_enable   <= 1'b0;
            r_key_seed     <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_CHUNK_LENGTH:     r_chunk_length <= i_cfg_data[COUNT_W-1:0];
                CFG_OBFUSCATE_ENABLE: r_obf_enable   <= i_cfg_data[0];
                CFG_KEY_SEED:         r_key_seed     <= i_cfg_data[ACC_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.out_byte    = r_out_byte;
    assign o_out.last_of_run = r_out_last;
    assign o_out.chunk_done  = r_out_done;

endmodule

// File: test/lz_window256_bit_decoder_tb.sv
`timescale 1ns / 100ps

module lz_window256_bit_decoder_tb
    import lzwd_pkg::*;
;

    localparam int SETTLE_CYCLES   = 16;
    localparam int STALL_LIMIT     = 2000;
    localparam int WINDOW_DEPTH_TB = 256;

    typedef struct packed {
        logic [BYTE_W-1:0] packed_byte;
        logic              chunk_start;
        logic              init_context;
        logic              load_key;
    } t_packed_req;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              last_of_run;
        logic              chunk_done;
    } t_decoded;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_we;
    t_cfg_index            cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    lzwd_in_if  in_if ();
    lzwd_out_if out_if ();

    lz_window256_bit_decoder DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in        (in_if),
        .o_out       (out_if)
    );

    // Requests waiting to be sent and decoded bytes waiting to arrive.
    t_packed_req packed_q[$];
    t_decoded    decoded_q[$];
    t_packed_req cur_req;
    int          queued_cnt;
    int          accepted_cnt;
    int          err_count;
    int          tx_gap;
    int          rx_stall;
    int          idle_cycles;
    bit          idle_on;

    // Register copies used by the predictor and the encoder.
    logic [COUNT_W-1:0] cfg_len;
    logic               cfg_obf;
    logic [ACC_W-1:0]   cfg_seed;

    // Predicted decoder state.
    logic [BYTE_W-1:0]  hist [WINDOW_DEPTH_TB];
    logic [BYTE_W-1:0]  wr_ptr;
    logic [BUF_W-1:0]   shift_reg;
    int                 shift_fill;
    logic [COUNT_W-1:0] decoded_cnt;
    logic [ACC_W-1:0]   xor_acc;

    // Encoder state for building packed chunks.
    logic [ACC_W-1:0]   enc_acc;
    logic [7:0]         enc_byte;
    int                 enc_fill;
    bit                 hdr_start;
    bit                 hdr_init;
    bit                 hdr_key;

    // Clock generation.
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Random idle length: mostly none or short, now and then long.
    function automatic int pick_gap();
        int r;
        if (!idle_on)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic flag_error(input string msg);
        $display("ERROR at %0t: %s", $time, msg);
        err_count++;
    endtask

    // Pulls n bits, most significant first, out of the predicted bit buffer.
    function automatic logic [7:0] take_bits(input int n);
        logic [BUF_W-1:0] field;
        field = (shift_reg >> (shift_fill - n)) & ((24'd1 << n) - 24'd1);
        shift_fill -= n;
        shift_reg &= (24'd1 << shift_fill) - 24'd1;
        return field[7:0];
    endfunction

    // Writes one byte to the predicted window and records it as expected.
    function automatic void emit_byte(input logic [7:0] b);
        t_decoded res;
        hist[wr_ptr] = b;
        wr_ptr++;
        decoded_cnt++;
        res.out_byte    = b;
        res.last_of_run = 1'b0;
        res.chunk_done  = (decoded_cnt >= cfg_len);
        decoded_q.push_back(res);
    endfunction

    // Works out the decoded bytes caused by one accepted request.
    function automatic void decode_packed(input t_packed_req req);
        logic [7:0] plain;
        logic [7:0] back_dist;
        logic [7:0] src;
        int         run_len;
        int         base;
        t_decoded   tail;
        plain = req.packed_byte;
        base  = decoded_q.size();
        if (req.init_context) begin
            foreach (hist[k])
                hist[k] = '0;
            wr_ptr = '0;
        end
        if (req.chunk_start) begin
            shift_reg   = '0;
            shift_fill  = 0;
            decoded_cnt = '0;
            if (!req.init_context)
                wr_ptr = wr_ptr + 8'(RING_ADVANCE);
        end
        if (req.load_key)
            xor_acc = cfg_seed;
        if (cfg_obf) begin
            plain   = req.packed_byte ^ xor_acc[7:0];
            xor_acc = (xor_acc >> 1) + 16'(req.packed_byte);
        end
        // Once the chunk is complete the bits are simply dropped.
        if (decoded_cnt >= cfg_len)
            return;
        shift_reg  = {shift_reg[15:0], plain};
        shift_fill += 8;
        if (shift_reg[shift_fill-1]) begin
            if (shift_fill >= LIT_BITS) begin
                void'(take_bits(1));
                emit_byte(take_bits(8));
            end
        end else if (shift_fill >= MATCH_BITS) begin
            void'(take_bits(1));
            run_len   = take_bits(2) + MIN_MATCH;
            back_dist = take_bits(8);
            src       = wr_ptr - back_dist - 8'd1;
            for (int k = 0; k < run_len && decoded_cnt < cfg_len; k++)
                emit_byte(hist[src + 8'(k)]);
        end
        if (decoded_q.size() > base) begin
            tail = decoded_q.pop_back();
            tail.last_of_run = 1'b1;
            decoded_q.push_back(tail);
        end
    endfunction

    // Queues one request, obfuscating the wanted plain byte when enabled.
    function automatic void queue_byte(input logic [7:0] plain, input bit start,
                                       input bit init, input bit key);
        t_packed_req req;
        if (key)
            enc_acc = cfg_seed;
        req.packed_byte  = cfg_obf ? (plain ^ enc_acc[7:0]) : plain;
        req.chunk_start  = start;
        req.init_context = init;
        req.load_key     = key;
        if (cfg_obf)
            enc_acc = (enc_acc >> 1) + 16'(req.packed_byte);
        packed_q.push_back(req);
        queued_cnt++;
    endfunction

    // Bit packer: appends token bits MSB first and queues each full byte.
    function automatic void put_bits(input logic [10:0] v, input int n);
        for (int k = n - 1; k >= 0; k--) begin
            enc_byte = {enc_byte[6:0], v[k]};
            enc_fill++;
            if (enc_fill == 8) begin
                queue_byte(enc_byte, hdr_start, hdr_init, hdr_key);
                {hdr_start, hdr_init, hdr_key} = 3'b000;
                enc_fill = 0;
            end
        end
    endfunction

    function automatic void put_literal(input logic [7:0] b);
        put_bits({2'b00, 1'b1, b}, 9);
    endfunction

    function automatic void put_match(input logic [1:0] code, input logic [7:0] back_dist);
        put_bits({1'b0, code, back_dist}, 11);
    endfunction

    function automatic void begin_chunk(input bit init, input bit key);
        hdr_start = 1'b1;
        hdr_init  = init;
        hdr_key   = key;
        enc_fill  = 0;
    endfunction

    // Pads the last byte of a chunk with random bits.
    function automatic void end_chunk();
        if (enc_fill != 0)
            put_bits(11'($urandom), 8 - enc_fill);
    endfunction

    task automatic write_reg(input t_cfg_index idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_CHUNK_LENGTH:     cfg_len  = val;
            CFG_OBFUSCATE_ENABLE: cfg_obf  = val[0];
            CFG_KEY_SEED:         cfg_seed = val;
            default: ;
        endcase
    endtask

    // Holds the sender back until every request is taken and every decoded
    // byte has arrived, then lets the block finish any silent work.
    task automatic wait_quiet();
        do
            @(posedge i_clk);
        while (accepted_cnt != queued_cnt || decoded_q.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Mostly well-formed chunks with random tokens, some stray requests.
    task automatic random_traffic(input int n);
        int target;
        int ntok;
        target = queued_cnt + n;
        while (queued_cnt < target) begin
            if ($urandom_range(0, 9) < 8) begin
                begin_chunk($urandom_range(0, 9) == 0,
                            cfg_obf ? ($urandom_range(0, 3) != 0)
                                    : ($urandom_range(0, 1) == 1));
                ntok = $urandom_range(2, 24);
                for (int t = 0; t < ntok; t++) begin
                    if ($urandom_range(0, 2) == 0)
                        put_literal(8'($urandom));
                    else if ($urandom_range(0, 3) == 0)
                        put_match(2'($urandom), 8'($urandom));
                    else
                        put_match(2'($urandom), 8'($urandom_range(0, 15)));
                end
                end_chunk();
            end else begin
                repeat ($urandom_range(1, 3))
                    queue_byte(8'($urandom), $urandom_range(0, 3) == 0,
                               $urandom_range(0, 7) == 0, $urandom_range(0, 3) == 0);
            end
        end
    endtask

    // Request driver: sends queued requests and predicts each accepted one.
    always @(posedge i_clk) begin : req_driver
        t_packed_req nxt;
        logic        drive_valid;
        if (!i_rst_n) begin
            in_if.valid        <= 1'b0;
            in_if.packed_byte  <= '0;
            in_if.chunk_start  <= 1'b0;
            in_if.init_context <= 1'b0;
            in_if.load_key     <= 1'b0;
            tx_gap = 0;
        end else begin
            drive_valid = in_if.valid;
            if (in_if.valid && in_if.ready) begin
                decode_packed(cur_req);
                accepted_cnt++;
                drive_valid = 1'b0;
                tx_gap = pick_gap();
            end
            if (!drive_valid) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                end else if (packed_q.size() > 0) begin
                    nxt = packed_q.pop_front();
                    cur_req = nxt;
                    drive_valid = 1'b1;
                    in_if.packed_byte  <= nxt.packed_byte;
                    in_if.chunk_start  <= nxt.chunk_start;
                    in_if.init_context <= nxt.init_context;
                    in_if.load_key     <= nxt.load_key;
                end
            end
            in_if.valid <= drive_valid;
        end
    end

    // Result monitor: checks each decoded byte against the oldest prediction.
    always @(posedge i_clk) begin : result_check
        t_decoded want;
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
            rx_stall = 0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                if (decoded_q.size() == 0) begin
                    flag_error($sformatf("unexpected byte %02h", out_if.out_byte));
                end else begin
                    want = decoded_q.pop_front();
                    if (out_if.out_byte !== want.out_byte)
                        flag_error($sformatf("out_byte %02h, expected %02h",
                                             out_if.out_byte, want.out_byte));
                    if (out_if.last_of_run !== want.last_of_run)
                        flag_error($sformatf("last_of_run %b, expected %b",
                                             out_if.last_of_run, want.last_of_run));
                    if (out_if.chunk_done !== want.chunk_done)
                        flag_error($sformatf("chunk_done %b, expected %b",
                                             out_if.chunk_done, want.chunk_done));
                end
                rx_stall = pick_gap();
            end
            if (rx_stall > 0) begin
                rx_stall--;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= 1'b1;
            end
        end
    end

    // Watchdog on cycles in which neither channel moves a request.
    always @(posedge i_clk) begin : watchdog
        if (!i_rst_n) begin
            idle_cycles <= 0;
        end else if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : stimulus
        // Known configuration values, predictor at its reset state.
        i_rst_n            = 1'b0;
        cfg_we             = 1'b0;
        cfg_index          = CFG_CHUNK_LENGTH;
        cfg_data           = '0;
        cfg_len            = '0;
        cfg_obf            = 1'b0;
        cfg_seed           = '0;
        foreach (hist[k])
            hist[k] = '0;
        wr_ptr             = '0;
        shift_reg          = '0;
        shift_fill         = 0;
        decoded_cnt        = '0;
        xor_acc            = '0;
        enc_acc            = '0;
        enc_byte           = '0;
        enc_fill           = 0;
        {hdr_start, hdr_init, hdr_key} = 3'b000;
        queued_cnt         = 0;
        idle_on            = 1'b1;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // With the chunk length still at zero nothing may come out.
        begin_chunk(1'b0, 1'b0);
        put_literal(8'h5A);
        end_chunk();
        wait_quiet();

        write_reg(CFG_CHUNK_LENGTH, 16'hFFFF);
        write_reg(CFG_OBFUSCATE_ENABLE, 16'h0000);
        write_reg(CFG_KEY_SEED, 16'h0000);

        // Extreme literals, overlapping copies and the farthest distance.
        begin_chunk(1'b0, 1'b0);
        put_literal(8'h00);
        put_literal(8'hFF);
        put_match(2'd0, 8'd0);
        put_match(2'd3, 8'd255);
        put_match(2'd3, 8'd0);
        put_literal(8'h81);
        end_chunk();

        // A fresh context: copies read back the cleared window.
        begin_chunk(1'b1, 1'b0);
        put_match(2'd3, 8'd17);
        put_literal(8'hA5);
        put_match(2'd1, 8'd0);
        end_chunk();
        wait_quiet();

        write_reg(CFG_CHUNK_LENGTH, 16'd3);
        write_reg(CFG_OBFUSCATE_ENABLE, 16'h0001);
        write_reg(CFG_KEY_SEED, 16'hFFFF);

        // The limit falls inside a match; later bytes only move the key.
        begin_chunk(1'b0, 1'b1);
        put_literal(8'h3C);
        put_match(2'd3, 8'd0);
        put_literal(8'h77);
        put_literal(8'hE1);
        end_chunk();
        wait_quiet();

        write_reg(CFG_KEY_SEED, 16'h0000);
        write_reg(CFG_CHUNK_LENGTH, 16'd1);

        // Start, context clear and key reload on the same byte, then a reload
        // in the middle of a finished chunk.
        begin_chunk(1'b1, 1'b1);
        put_literal(8'hC3);
        put_literal(8'h11);
        end_chunk();
        queue_byte(8'($urandom), 1'b0, 1'b0, 1'b1);
        wait_quiet();

        // Random traffic in the clear, first without idling, then with it
        // after the sender has held back until everything has drained.
        idle_on = 1'b0;
        write_reg(CFG_OBFUSCATE_ENABLE, 16'h0000);
        write_reg(CFG_CHUNK_LENGTH, 16'($urandom_range(8, 40)));
        random_traffic(15);
        wait_quiet();
        idle_on = 1'b1;
        random_traffic(15);
        wait_quiet();

        // Random traffic with de-obfuscation and a random key.
        write_reg(CFG_OBFUSCATE_ENABLE, 16'h0001);
        write_reg(CFG_KEY_SEED, 16'($urandom));
        write_reg(CFG_CHUNK_LENGTH, 16'($urandom_range(16, 48)));
        random_traffic(30);
        wait_quiet();

        if (err_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
